FILE: design/pes_pkg.sv
`default_nettype none

package pes_pkg;

    // Default build values for the top level parameters
    localparam int MAX_SEGMENTS_DEF = 32;
    localparam int COORD_WIDTH_DEF  = 32;

    // Segment count register
    localparam int             CFG_WIDTH = 6;
    localparam logic [5:0]     CFG_RESET = 6'd1;

    // Axis count and the index of the last of the three axes
    localparam int             NUM_AXES  = 3;
    localparam logic [1:0]     AXIS_LAST = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_RUN,
        S_POINT,
        S_PUSH
    } t_state;

endpackage

`default_nettype wire

FILE: design/pes_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, unsigned operands.
module pes_div #(
    parameter int DVD_W = 33,
    parameter int DVS_W = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quotient,
    output logic [DVS_W-1:0]      o_remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dq;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W-1:0] n_rem;

    // Shift in the next dividend bit and try one subtraction
    always_comb begin
        trial = {r_rem, r_dq[DVD_W-1]};
        ge    = trial >= {1'b0, r_dvs};
        if (ge) begin
            n_rem = DVS_W'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = trial[DVS_W-1:0];
        end
    end

    // Control: step through every dividend bit, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits replace dividend bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dq  <= {r_dq[DVD_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_dq;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

FILE: design/polygon_edge_subdivider.sv
`default_nettype none

// Polygon edge subdivider.
// Corners of a closed polygon arrive as beats on the s_axis channel, x/y/z in
// tdata and the last corner marked by tlast. Each corner after the first emits
// n = segments_per_edge points along the edge from the previous corner; the
// last corner also emits the closing edge back to the first corner. Points
// leave on m_axis, with tlast on the final point caused by that corner.
// The segment count is written on the cfg channel (always ready); the user
// must do so only while idle, which the block itself does not enforce. Zero
// reads as 1 and values above MAX_SEGMENTS saturate. A first, non-final
// corner is only stored. Each edge runs one division per axis in the shared
// serial divider (one quotient bit per cycle) and then steps each point
// through the shared step unit, one axis a cycle, before the push, which waits
// on a stalled receiver; a closing corner runs its own edge, then the closing edge.
// s_axis_tready is high only while the block is idle. Points pass through a
// single output register, so a stalled receiver holds the sequencer in its
// push step with no point lost. Reset clears the polygon, the output
// register and sets the segment count to 1.
module polygon_edge_subdivider #(
    parameter int MAX_SEGMENTS = pes_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_WIDTH  = pes_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // corner_x, corner_y, corner_z from bit 0 up, zero padded to bytes
    input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic                  s_axis_tlast,
    // point_x, point_y, point_z from bit 0 up, zero padded to bytes
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic                       m_axis_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [pes_pkg::CFG_WIDTH-1:0] i_cfg_data
);

    localparam int W      = COORD_WIDTH;
    localparam int DW     = COORD_WIDTH + 1;
    localparam int NW     = $clog2(MAX_SEGMENTS + 1);
    localparam int DATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int CFG_W  = pes_pkg::CFG_WIDTH;

    pes_pkg::t_state r_state;
    pes_pkg::t_state n_state;

    logic [CFG_W-1:0] r_seg_cfg;
    logic [NW-1:0]    seg_sat;
    logic [NW-1:0]    r_n;
    logic [NW-1:0]    r_j;
    logic [1:0]       r_c;
    logic             r_open;
    logic             r_more;

    logic [W-1:0]     r_cur   [pes_pkg::NUM_AXES];
    logic [W-1:0]     r_first [pes_pkg::NUM_AXES];
    logic [W-1:0]     r_prev  [pes_pkg::NUM_AXES];
    logic [W-1:0]     r_src   [pes_pkg::NUM_AXES];
    logic [W-1:0]     r_dst   [pes_pkg::NUM_AXES];
    logic             r_neg   [pes_pkg::NUM_AXES];
    logic [DW-1:0]    r_qd    [pes_pkg::NUM_AXES];
    logic [NW-1:0]    r_rd    [pes_pkg::NUM_AXES];
    logic [DW-1:0]    r_acc_q [pes_pkg::NUM_AXES];
    logic [NW-1:0]    r_acc_r [pes_pkg::NUM_AXES];
    logic [W-1:0]     r_pt    [pes_pkg::NUM_AXES];
    logic [W-1:0]     r_out   [pes_pkg::NUM_AXES];
    logic             r_out_valid;
    logic             r_out_last;

    logic [W-1:0]     in_c [pes_pkg::NUM_AXES];
    logic             in_acc;
    logic             out_free;
    logic             last_j;
    logic             div_start;
    logic             div_done;
    logic [DW-1:0]    div_quo;
    logic [NW-1:0]    div_rem;

    logic [DW-1:0]    diff;
    logic             diff_neg;
    logic [DW-1:0]    diff_mag;
    logic [W-1:0]     pt;
    logic [NW:0]      rsum;
    logic             wrap;
    logic [NW-1:0]    n_acc_r;
    logic [DW-1:0]    n_acc_q;

    // Unpack corner coordinates
    always_comb begin
        for (int c = 0; c < pes_pkg::NUM_AXES; c++) begin
            in_c[c] = s_axis_tdata[c*W +: W];
        end
    end

    // Clamp the segment count to 1..MAX_SEGMENTS
    always_comb begin
        if (r_seg_cfg == '0) begin
            seg_sat = NW'(1);
        end else if (r_seg_cfg > CFG_W'(MAX_SEGMENTS)) begin
            seg_sat = NW'(MAX_SEGMENTS);
        end else begin
            seg_sat = NW'(r_seg_cfg);
        end
    end

    // Edge delta magnitude and sign for the current axis
    always_comb begin
        diff     = {r_dst[r_c][W-1], r_dst[r_c]} - {r_src[r_c][W-1], r_src[r_c]};
        diff_neg = diff[DW-1];
        diff_mag = diff_neg ? (~diff + 1'b1) : diff;
    end

    // Shared step unit: emit src +/- floor(j*|d|/n), then advance j by one
    always_comb begin
        pt      = r_neg[r_c] ? (r_src[r_c] - W'(r_acc_q[r_c]))
                             : (r_src[r_c] + W'(r_acc_q[r_c]));
        rsum    = {1'b0, r_acc_r[r_c]} + {1'b0, r_rd[r_c]};
        wrap    = rsum >= {1'b0, r_n};
        n_acc_r = wrap ? NW'(rsum - {1'b0, r_n}) : rsum[NW-1:0];
        n_acc_q = r_acc_q[r_c] + r_qd[r_c] + DW'(wrap);
    end

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign last_j   = r_j == (r_n - 1'b1);

    pes_div #(
        .DVD_W (DW),
        .DVS_W (NW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (diff_mag),
        .i_divisor   (r_n),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pes_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and sequencer outputs
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        unique case (r_state)
            pes_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (r_open || s_axis_tlast)) begin
                    n_state = pes_pkg::S_DIV_GO;
                end
            end
            pes_pkg::S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = pes_pkg::S_DIV_RUN;
            end
            pes_pkg::S_DIV_RUN: begin
                if (div_done) begin
                    n_state = (r_c == pes_pkg::AXIS_LAST) ? pes_pkg::S_POINT
                                                          : pes_pkg::S_DIV_GO;
                end
            end
            pes_pkg::S_POINT: begin
                if (r_c == pes_pkg::AXIS_LAST) begin
                    n_state = pes_pkg::S_PUSH;
                end
            end
            pes_pkg::S_PUSH: begin
                if (out_free) begin
                    if (!last_j) begin
                        n_state = pes_pkg::S_POINT;
                    end else if (r_more) begin
                        n_state = pes_pkg::S_DIV_GO;
                    end else begin
                        n_state = pes_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = pes_pkg::S_IDLE;
            end
        endcase
    end

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_cfg <= pes_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_seg_cfg <= i_cfg_data;
        end
    end

    // Polygon control: open flag, pending closing edge, axis index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_more <= 1'b0;
            r_c    <= '0;
        end else begin
            unique case (r_state)
                pes_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_c <= '0;
                        if (!r_open) begin
                            r_open <= !s_axis_tlast;
                            r_more <= 1'b0;
                        end else begin
                            r_open <= !s_axis_tlast;
                            r_more <= s_axis_tlast;
                        end
                    end
                end
                pes_pkg::S_DIV_GO: begin
                end
                pes_pkg::S_DIV_RUN: begin
                    if (div_done) begin
                        r_c <= (r_c == pes_pkg::AXIS_LAST) ? 2'd0 : r_c + 1'b1;
                    end
                end
                pes_pkg::S_POINT: begin
                    r_c <= (r_c == pes_pkg::AXIS_LAST) ? 2'd0 : r_c + 1'b1;
                end
                pes_pkg::S_PUSH: begin
                    if (out_free && last_j && r_more) begin
                        r_more <= 1'b0;
                        r_c    <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Corner storage, edge setup and step accumulators
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pes_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_n <= seg_sat;
                    for (int c = 0; c < pes_pkg::NUM_AXES; c++) begin
                        r_cur[c]  <= in_c[c];
                        r_prev[c] <= in_c[c];
                        r_dst[c]  <= in_c[c];
                        if (!r_open) begin
                            r_first[c] <= in_c[c];
                            r_src[c]   <= in_c[c];
                        end else begin
                            r_src[c]   <= r_prev[c];
                        end
                    end
                end
            end
            pes_pkg::S_DIV_GO: begin
                r_neg[r_c] <= diff_neg;
            end
            pes_pkg::S_DIV_RUN: begin
                if (div_done) begin
                    r_qd[r_c] <= div_quo;
                    r_rd[r_c] <= div_rem;
                    if (r_c == pes_pkg::AXIS_LAST) begin
                        r_j <= '0;
                        for (int c = 0; c < pes_pkg::NUM_AXES; c++) begin
                            r_acc_q[c] <= '0;
                            r_acc_r[c] <= '0;
                        end
                    end
                end
            end
            pes_pkg::S_POINT: begin
                r_pt[r_c]    <= pt;
                r_acc_q[r_c] <= n_acc_q;
                r_acc_r[r_c] <= n_acc_r;
            end
            pes_pkg::S_PUSH: begin
                if (out_free) begin
                    if (!last_j) begin
                        r_j <= r_j + 1'b1;
                    end else if (r_more) begin
                        // Set up the closing edge back to the first corner
                        for (int c = 0; c < pes_pkg::NUM_AXES; c++) begin
                            r_src[c] <= r_cur[c];
                            r_dst[c] <= r_first[c];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: load a finished point, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == pes_pkg::S_PUSH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pes_pkg::S_PUSH && out_free) begin
            r_out_last <= last_j && !r_more;
            for (int c = 0; c < pes_pkg::NUM_AXES; c++) begin
                r_out[c] <= r_pt[c];
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = DATA_W'({r_out[2], r_out[1], r_out[0]});

endmodule

`default_nettype wire

FILE: design/pes_checker.sv
`default_nettype none

module pes_checker #(
    parameter int COORD_WIDTH = pes_pkg::COORD_WIDTH_DEF
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  s_axis_tlast,
    input wire logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic                  m_axis_tlast
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // A closing corner always starts work, so the input side must drop ready
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("ready stayed high after a closing corner");

    // New points are only produced while the input side is busy
    a_new_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("point appeared while idle");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind polygon_edge_subdivider pes_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_pes_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
